/* hw/rtl/dpad_socd_cleaner_top_defines.svh */
// Assertion macros used by the top-level RTL file of the d-pad SOCD cleaner.
`ifndef DPAD_SOCD_CLEANER_TOP_DEFINES_SVH
`define DPAD_SOCD_CLEANER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define DSC_ASSERT_HOLDS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("dsc assertion failed");

`define DSC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dsc assertion failed");

`define DSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dsc assertion failed");

`else

`define DSC_ASSERT_HOLDS(label, clk, rst, prop)
`define DSC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define DSC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* hw/rtl/dsc_pkg.sv */
package dsc_pkg;

   localparam int NUM_PORTS_DEFAULT = 4;

   localparam logic [1:0] MODE_OFF     = 2'd0;
   localparam logic [1:0] MODE_NEUTRAL = 2'd1;
   localparam logic [1:0] MODE_LAST    = 2'd2;
   localparam logic [1:0] MODE_FIRST   = 2'd3;

   localparam logic [1:0] EXEMPT_NONE  = 2'd0;
   localparam logic [1:0] EXEMPT_ALT   = 2'd1;
   localparam logic [1:0] EXEMPT_LR    = 2'd2;
   localparam logic [1:0] EXEMPT_ALL   = 2'd3;

   localparam logic [1:0] CSR_SOCD_MODE    = 2'd0;
   localparam logic [1:0] CSR_EXEMPT_RULE  = 2'd1;
   localparam logic [1:0] CSR_ACTIVE_PORTS = 2'd2;

   localparam logic [2:0] ACTIVE_PORTS_RESET = 3'd4;

   typedef struct packed {
      logic [1:0] mode;
      logic       exempt;
   } axis_ctl_type;

endpackage

/* hw/rtl/dsc_axis.sv */
module dsc_axis (
   input  dsc_pkg::axis_ctl_type ctl,
   input  logic                  a,
   input  logic                  b,
   input  logic [1:0]            held,
   output logic                  a_out,
   output logic                  b_out,
   output logic [1:0]            held_out
);

   logic conflict;
   logic any_held;

   assign conflict = a & b & ~ctl.exempt;
   assign any_held = |held;

   always_comb begin
      a_out    = a;
      b_out    = b;
      held_out = {b, a};
      if (conflict) begin
         held_out = held;
         priority if (ctl.mode == dsc_pkg::MODE_NEUTRAL) begin
            a_out = 1'b0;
            b_out = 1'b0;
         end else if (ctl.mode == dsc_pkg::MODE_LAST && any_held) begin
            a_out = held[1];
            b_out = held[0];
         end else if (ctl.mode == dsc_pkg::MODE_FIRST && any_held) begin
            a_out = held[0];
            b_out = held[1];
         end else begin
            held_out = 2'b00;
         end
      end
   end

endmodule

/* hw/rtl/dpad_socd_cleaner_top.sv */
// channel  | handshake                 | payload
// req_     | req_valid / req_stall     | req_port, req_in_up/down/left/right
// rsp_     | rsp_valid / rsp_stall     | rsp_out_port, rsp_out_up/down/left/right
// csr_     | csr_valid / csr_ready     | csr_index, csr_wdata
//
// One sample per cycle sustained while rsp_stall is low; an accepted sample goes through
// the input register and the result register around the cleaning logic to rsp_valid.
// The per-port held state is read and written in the same cycle, so no forwarding is needed.
// Synchronous reset clears the held state, the CSR registers and both valid flags.
// A stalled result keeps one more sample in the input register before req_stall rises.
module dpad_socd_cleaner_top #(
   parameter int NUM_PORTS = dsc_pkg::NUM_PORTS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_port,
   input  logic       req_in_up,
   input  logic       req_in_down,
   input  logic       req_in_left,
   input  logic       req_in_right,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_out_port,
   output logic       rsp_out_up,
   output logic       rsp_out_down,
   output logic       rsp_out_left,
   output logic       rsp_out_right,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [2:0] csr_wdata
);

`include "dpad_socd_cleaner_top_defines.svh"

   localparam int IDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
   localparam logic [4:0] NUM_PORTS_V = 5'(NUM_PORTS);

   logic [1:0] mode_ff;
   logic [1:0] exempt_ff;
   logic [2:0] active_ff;

   logic [NUM_PORTS-1:0][3:0] held_ff;

   logic       s1_valid_ff, s1_valid_in;
   logic [1:0] s1_port_ff;
   logic [3:0] s1_dir_ff;

   logic       out_valid_ff, out_valid_in;
   logic [1:0] out_port_ff;
   logic [3:0] out_dir_ff, out_dir_in;

   logic             out_ready;
   logic             s1_adv;
   logic             req_take;
   logic             active;
   logic [IDX_W-1:0] idx;
   logic [3:0]       held_rd;
   logic             ex_ud, ex_lr;
   logic             u_o, d_o, l_o, r_o;
   logic [1:0]       ud_held, lr_held;

   dsc_pkg::axis_ctl_type ud_ctl, lr_ctl;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= dsc_pkg::MODE_OFF;
         exempt_ff <= dsc_pkg::EXEMPT_NONE;
         active_ff <= dsc_pkg::ACTIVE_PORTS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            dsc_pkg::CSR_SOCD_MODE:    mode_ff   <= csr_wdata[1:0];
            dsc_pkg::CSR_EXEMPT_RULE:  exempt_ff <= csr_wdata[1:0];
            dsc_pkg::CSR_ACTIVE_PORTS: active_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign out_ready = ~out_valid_ff | ~rsp_stall;
   assign s1_adv    = s1_valid_ff & out_ready;
   assign req_stall = s1_valid_ff & ~out_ready;
   assign req_take  = req_valid & ~req_stall;

   assign s1_valid_in  = req_take | (s1_valid_ff & ~s1_adv);
   assign out_valid_in = s1_adv | (out_valid_ff & ~out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_port_ff <= req_port;
         s1_dir_ff  <= {req_in_right, req_in_left, req_in_down, req_in_up};
      end
      if (s1_adv) begin
         out_port_ff <= s1_port_ff;
         out_dir_ff  <= out_dir_in;
      end
   end

   assign idx     = IDX_W'(s1_port_ff);
   assign held_rd = held_ff[idx];
   assign active  = (mode_ff != dsc_pkg::MODE_OFF)
                  && ({1'b0, s1_port_ff} < active_ff)
                  && ({3'b000, s1_port_ff} < NUM_PORTS_V);

   always_comb begin
      ex_ud = 1'b0;
      ex_lr = 1'b0;
      unique case (exempt_ff)
         dsc_pkg::EXEMPT_NONE: ;
         dsc_pkg::EXEMPT_ALT: begin
            ex_lr = s1_dir_ff[2] & s1_dir_ff[3];
            ex_ud = s1_dir_ff[0] & s1_dir_ff[1] & ~ex_lr;
         end
         dsc_pkg::EXEMPT_LR: ex_lr = s1_dir_ff[2] & s1_dir_ff[3];
         dsc_pkg::EXEMPT_ALL: begin
            ex_lr = 1'b1;
            ex_ud = 1'b1;
         end
      endcase
   end

   assign ud_ctl = '{mode: mode_ff, exempt: ex_ud};
   assign lr_ctl = '{mode: mode_ff, exempt: ex_lr};

   dsc_axis u_axis_ud (
      .ctl      (ud_ctl),
      .a        (s1_dir_ff[0]),
      .b        (s1_dir_ff[1]),
      .held     (held_rd[1:0]),
      .a_out    (u_o),
      .b_out    (d_o),
      .held_out (ud_held)
   );

   dsc_axis u_axis_lr (
      .ctl      (lr_ctl),
      .a        (s1_dir_ff[2]),
      .b        (s1_dir_ff[3]),
      .held     (held_rd[3:2]),
      .a_out    (l_o),
      .b_out    (r_o),
      .held_out (lr_held)
   );

   assign out_dir_in = active ? {r_o, l_o, d_o, u_o} : s1_dir_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else if (s1_adv && active) begin
         held_ff[idx] <= {lr_held, ud_held};
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_port  = out_port_ff;
   assign rsp_out_up    = out_dir_ff[0];
   assign rsp_out_down  = out_dir_ff[1];
   assign rsp_out_left  = out_dir_ff[2];
   assign rsp_out_right = out_dir_ff[3];

   `DSC_ASSERT_IMPL(a_stall_only_when_full, clock, reset, req_stall, s1_valid_ff)
   `DSC_ASSERT_NEXT(a_adv_fills_output, clock, reset, s1_adv, rsp_valid)
   `DSC_ASSERT_NEXT(a_inactive_keeps_state, clock, reset, !(s1_adv && active), $stable(held_ff))
   `DSC_ASSERT_NEXT(a_bypass, clock, reset, s1_adv && !active, out_dir_ff == $past(s1_dir_ff))
   `DSC_ASSERT_NEXT(a_port_echo, clock, reset, s1_adv, rsp_out_port == $past(s1_port_ff))

endmodule
